[rtl/vehicle_drive_state_sequencer_assert.svh]
// Assertion macros for the drive state sequencer.
// Included by the top level; no other dependencies.
`ifndef VEHICLE_DRIVE_STATE_SEQUENCER_ASSERT_SVH
`define VEHICLE_DRIVE_STATE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define VDSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vdss: same-cycle check failed");

// next-cycle implication
`define VDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vdss: next-cycle check failed");

`endif

[rtl/vdss_pkg.sv]
// Shared types, codes and encoders for the drive state sequencer.
// No dependencies; imported by every module of the block.
package vdss_pkg;

    localparam int SOUND_COUNT_BITS = 16;
    localparam int SOUND_MS_W       = 16;
    localparam int CMP_W = (SOUND_COUNT_BITS > SOUND_MS_W) ? SOUND_COUNT_BITS : SOUND_MS_W;

    localparam logic [1:0] CFG_READY_SOUND_MS  = 2'd0;
    localparam logic [1:0] CFG_LAUNCH_ARM      = 2'd1;
    localparam logic [1:0] CFG_LAUNCH_ABORT    = 2'd2;

    localparam logic [15:0] READY_SOUND_MS_RST = 16'd2000;
    localparam logic [9:0]  LAUNCH_ARM_RST     = 10'd800;
    localparam logic [9:0]  LAUNCH_ABORT_RST   = 10'd500;

    localparam logic [2:0] DS_STARTUP  = 3'd0;
    localparam logic [2:0] DS_HV_OFF   = 3'd1;
    localparam logic [2:0] DS_HV_ON    = 3'd2;
    localparam logic [2:0] DS_ENABLING = 3'd3;
    localparam logic [2:0] DS_BUZZER   = 3'd4;
    localparam logic [2:0] DS_DRIVE    = 3'd5;

    localparam logic [1:0] LP_IDLE      = 2'd0;
    localparam logic [1:0] LP_WAITING   = 2'd1;
    localparam logic [1:0] LP_LAUNCHING = 2'd2;
    localparam logic [1:0] LP_FINISHED  = 2'd3;

    typedef enum logic [5:0] {
        MS_STARTUP  = 6'b000001,
        MS_HV_OFF   = 6'b000010,
        MS_HV_ON    = 6'b000100,
        MS_ENABLING = 6'b001000,
        MS_BUZZER   = 6'b010000,
        MS_DRIVE    = 6'b100000
    } main_st_t;

    typedef enum logic [3:0] {
        LS_IDLE      = 4'b0001,
        LS_WAITING   = 4'b0010,
        LS_LAUNCHING = 4'b0100,
        LS_FINISHED  = 4'b1000
    } launch_st_t;

    typedef struct packed {
        logic [15:0] ready_sound_ms;
        logic [9:0]  launch_arm_permille;
        logic [9:0]  launch_abort_permille;
    } cfg_t;

    typedef struct packed {
        main_st_t                    main_state;
        logic [SOUND_COUNT_BITS-1:0] sound_count;
        logic                        launch_on;
        launch_st_t                  launch_step;
        logic                        speed_flag;
    } state_t;

    typedef struct packed {
        logic       time_tick;
        logic [2:0] precharge_status;
        logic [3:0] inverter_status;
        logic [4:0] dash_buttons;
        logic       brake_active;
        logic [9:0] pedal_travel;
        logic       pedal_fault;
    } in_item_t;

    typedef struct packed {
        logic [2:0] drive_state;
        logic       inverter_enable;
        logic       buzzer_on;
        logic       lowside_on;
        logic       launch_active;
        logic [1:0] launch_phase;
        logic       speed_mode;
        logic       precharge_request;
        logic       precharge_reset;
        logic       discharge_request;
        logic       inverter_start;
        logic       state_changed;
    } out_item_t;

    function automatic logic [2:0] ds_code(main_st_t s);
        logic [2:0] c;
        unique case (s)
            MS_STARTUP:  c = DS_STARTUP;
            MS_HV_OFF:   c = DS_HV_OFF;
            MS_HV_ON:    c = DS_HV_ON;
            MS_ENABLING: c = DS_ENABLING;
            MS_BUZZER:   c = DS_BUZZER;
            MS_DRIVE:    c = DS_DRIVE;
            default:     c = DS_STARTUP;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] lp_code(launch_st_t s);
        logic [1:0] c;
        unique case (s)
            LS_IDLE:      c = LP_IDLE;
            LS_WAITING:   c = LP_WAITING;
            LS_LAUNCHING: c = LP_LAUNCHING;
            LS_FINISHED:  c = LP_FINISHED;
            default:      c = LP_IDLE;
        endcase
        return c;
    endfunction

endpackage

[rtl/vdss_cfg_if.sv]
// Configuration write channel: register index and write data.
// No dependencies.
interface vdss_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/vdss_in_if.sv]
// Status channel: one control-loop pass per beat.
// No dependencies.
interface vdss_in_if;
    logic       valid;
    logic       ready;
    logic       time_tick;
    logic [2:0] precharge_status;
    logic [3:0] inverter_status;
    logic [4:0] dash_buttons;
    logic       brake_active;
    logic [9:0] pedal_travel;
    logic       pedal_fault;

    modport source (output valid, time_tick, precharge_status, inverter_status, dash_buttons,
                    brake_active, pedal_travel, pedal_fault, input ready);
    modport sink (input valid, time_tick, precharge_status, inverter_status, dash_buttons,
                  brake_active, pedal_travel, pedal_fault, output ready);
endinterface

[rtl/vdss_out_if.sv]
// Result channel: drive state, levels and action pulses, one beat per pass.
// No dependencies.
interface vdss_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] drive_state;
    logic       inverter_enable;
    logic       buzzer_on;
    logic       lowside_on;
    logic       launch_active;
    logic [1:0] launch_phase;
    logic       speed_mode;
    logic       precharge_request;
    logic       precharge_reset;
    logic       discharge_request;
    logic       inverter_start;
    logic       state_changed;

    modport source (output valid, drive_state, inverter_enable, buzzer_on, lowside_on,
                    launch_active, launch_phase, speed_mode, precharge_request,
                    precharge_reset, discharge_request, inverter_start, state_changed,
                    input ready);
    modport sink (input valid, drive_state, inverter_enable, buzzer_on, lowside_on,
                  launch_active, launch_phase, speed_mode, precharge_request,
                  precharge_reset, discharge_request, inverter_start, state_changed,
                  output ready);
endinterface

[rtl/vdss_cfg_regs.sv]
// Configuration registers: buzzer duration and launch thresholds.
// Depends on vdss_pkg and vdss_cfg_if.
module vdss_cfg_regs
    import vdss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vdss_cfg_if.sink    cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ready_sound_ms        <= READY_SOUND_MS_RST;
            regs_reg.launch_arm_permille   <= LAUNCH_ARM_RST;
            regs_reg.launch_abort_permille <= LAUNCH_ABORT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_READY_SOUND_MS: regs_reg.ready_sound_ms        <= cfg.data;
                CFG_LAUNCH_ARM:     regs_reg.launch_arm_permille   <= cfg.data[9:0];
                CFG_LAUNCH_ABORT:   regs_reg.launch_abort_permille <= cfg.data[9:0];
                default:            regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

[rtl/vdss_step.sv]
// Next-state and result logic for one control-loop pass.
// Depends on vdss_pkg.
module vdss_step
    import vdss_pkg::*;
(
    input  state_t    state_cur,
    input  cfg_t      regs,
    input  in_item_t  item,
    output state_t    state_next,
    output out_item_t res_next
);

    logic attempted, success, timeout;
    logic hv, en_to, inv_ready, disabled;
    logic b_start, b_speed, b_lctog, b_lc, b_rel;
    logic kick, pchg_req, pchg_rst, discharge, inv_start, changed;
    logic [SOUND_COUNT_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]            cnt_ext;
    logic [CMP_W-1:0]            ms_ext;
    logic arm_ok, abort_low;
    main_st_t target;

    assign attempted = item.precharge_status[0];
    assign success   = item.precharge_status[1];
    assign timeout   = item.precharge_status[2];
    assign hv        = item.inverter_status[0];
    assign en_to     = item.inverter_status[1];
    assign inv_ready = item.inverter_status[2];
    assign disabled  = item.inverter_status[3];
    assign b_start   = item.dash_buttons[0];
    assign b_speed   = item.dash_buttons[1];
    assign b_lctog   = item.dash_buttons[2];
    assign b_lc      = item.dash_buttons[3];
    assign b_rel     = item.dash_buttons[4];

    // saturating ms count
    assign cnt_inc = (item.time_tick && !(&state_cur.sound_count))
                   ? state_cur.sound_count + {{(SOUND_COUNT_BITS-1){1'b0}}, 1'b1}
                   : state_cur.sound_count;
    assign cnt_ext = CMP_W'(cnt_inc);
    assign ms_ext  = CMP_W'(regs.ready_sound_ms);

    assign arm_ok    = item.pedal_travel > regs.launch_arm_permille;
    assign abort_low = item.pedal_travel < regs.launch_abort_permille;

    always_comb
    begin
        state_next = state_cur;
        target     = state_cur.main_state;
        kick       = 1'b0;
        pchg_req   = 1'b0;
        pchg_rst   = 1'b0;
        discharge  = 1'b0;
        inv_start  = 1'b0;
        changed    = 1'b0;

        unique case (state_cur.main_state)
            MS_STARTUP:
                target = MS_HV_OFF;
            MS_HV_OFF:
            begin
                pchg_req = !attempted || (timeout && !success);
                if (success && !timeout && hv)
                    target = MS_HV_ON;
            end
            MS_HV_ON:
            begin
                if (!hv || timeout)
                    target = MS_HV_OFF;
                else if (b_start && item.brake_active)
                    target = MS_ENABLING;
            end
            MS_ENABLING:
            begin
                kick = 1'b1;
                if (!hv || timeout)
                    target = MS_HV_OFF;
                else if (en_to)
                    target = MS_HV_ON;
                else if (inv_ready)
                    target = MS_BUZZER;
            end
            MS_BUZZER:
            begin
                kick = 1'b1;
                if (!hv)
                    target = MS_HV_OFF;
                else if (disabled)
                    target = MS_HV_ON;
                else
                begin
                    state_next.sound_count = cnt_inc;
                    if (cnt_ext >= ms_ext)
                        target = MS_DRIVE;
                end
            end
            MS_DRIVE:
            begin
                kick = 1'b1;
                if (!hv)
                    target = MS_HV_OFF;
                else if (disabled)
                    target = MS_HV_ON;
                else if (timeout)
                    target = MS_HV_OFF;
                else
                begin
                    state_next.speed_flag = state_cur.speed_flag ^ b_speed;
                    if (b_lctog)
                    begin
                        state_next.launch_on   = !state_cur.launch_on;
                        state_next.launch_step = LS_IDLE;
                    end
                    if (state_next.launch_on)
                    begin
                        unique case (state_next.launch_step)
                            LS_IDLE:
                                if (b_lc && arm_ok && !item.brake_active && !item.pedal_fault)
                                    state_next.launch_step = LS_WAITING;
                            LS_WAITING:
                                if (abort_low)
                                    state_next.launch_step = LS_IDLE;
                                else if (arm_ok && !b_lc && b_rel)
                                    state_next.launch_step = LS_LAUNCHING;
                            LS_LAUNCHING:
                                if (item.brake_active || item.pedal_fault)
                                    state_next.launch_step = LS_FINISHED;
                            default:
                                state_next.launch_on = 1'b0;
                        endcase
                    end
                end
            end
            default:
                target = MS_HV_OFF;
        endcase

        // transition actions
        if (target != state_cur.main_state)
        begin
            state_next.main_state = target;
            changed = 1'b1;
            if (state_cur.main_state == MS_HV_ON || state_cur.main_state == MS_DRIVE)
                pchg_rst = 1'b1;
            if (state_cur.main_state == MS_DRIVE)
                state_next.launch_on = 1'b0;
            discharge = (target == MS_HV_OFF);
            inv_start = (target == MS_ENABLING);
            if (target == MS_BUZZER)
                state_next.sound_count = '0;
        end
    end

    always_comb
    begin
        res_next.drive_state       = ds_code(state_next.main_state);
        res_next.inverter_enable   = kick;
        res_next.buzzer_on         = (state_next.main_state == MS_BUZZER);
        res_next.lowside_on        = (state_next.main_state == MS_DRIVE);
        res_next.launch_active     = state_next.launch_on;
        res_next.launch_phase      = lp_code(state_next.launch_step);
        res_next.speed_mode        = state_next.speed_flag;
        res_next.precharge_request = pchg_req;
        res_next.precharge_reset   = pchg_rst;
        res_next.discharge_request = discharge;
        res_next.inverter_start    = inv_start;
        res_next.state_changed     = changed;
    end

endmodule

[rtl/vehicle_drive_state_sequencer.sv]
// Electric-drive state sequencer: six-state drive sequence with launch control.
// Depends on vdss_pkg, the channel interfaces, vdss_cfg_regs, vdss_step and the assert header.
// Each status beat is one control-loop pass and yields exactly one result beat. A beat is
// registered in the input register on acceptance, the combinational next-state step works
// from that register and the result is held in an output register, so one beat is taken
// every clock while the result side keeps up. The sequence state is updated as each result
// is registered; the combinational step sets the rate. Configuration writes are taken every
// cycle and belong in idle periods.
`include "vehicle_drive_state_sequencer_assert.svh"

module vehicle_drive_state_sequencer
    import vdss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vdss_cfg_if.sink    cfg,
    vdss_in_if.sink     status,
    vdss_out_if.source  result
);

    cfg_t      regs;
    in_item_t  in_reg;
    logic      in_valid_reg;
    state_t    state_reg;
    state_t    state_next;
    out_item_t out_reg;
    out_item_t out_next;
    logic      out_valid_reg;
    logic      adv;

    vdss_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    vdss_step u_step (
        .state_cur  (state_reg),
        .regs       (regs),
        .item       (in_reg),
        .state_next (state_next),
        .res_next   (out_next)
    );

    assign adv          = in_valid_reg && (!out_valid_reg || result.ready);
    assign status.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (status.ready)
            in_valid_reg <= status.valid;
    end

    always_ff @(posedge clk)
    begin
        if (status.valid && status.ready)
        begin
            in_reg.time_tick        <= status.time_tick;
            in_reg.precharge_status <= status.precharge_status;
            in_reg.inverter_status  <= status.inverter_status;
            in_reg.dash_buttons     <= status.dash_buttons;
            in_reg.brake_active     <= status.brake_active;
            in_reg.pedal_travel     <= status.pedal_travel;
            in_reg.pedal_fault      <= status.pedal_fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.main_state  <= MS_STARTUP;
            state_reg.sound_count <= '0;
            state_reg.launch_on   <= 1'b0;
            state_reg.launch_step <= LS_IDLE;
            state_reg.speed_flag  <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.drive_state       = out_reg.drive_state;
    assign result.inverter_enable   = out_reg.inverter_enable;
    assign result.buzzer_on         = out_reg.buzzer_on;
    assign result.lowside_on        = out_reg.lowside_on;
    assign result.launch_active     = out_reg.launch_active;
    assign result.launch_phase      = out_reg.launch_phase;
    assign result.speed_mode        = out_reg.speed_mode;
    assign result.precharge_request = out_reg.precharge_request;
    assign result.precharge_reset   = out_reg.precharge_reset;
    assign result.discharge_request = out_reg.discharge_request;
    assign result.inverter_start    = out_reg.inverter_start;
    assign result.state_changed     = out_reg.state_changed;

    // launch mode only survives inside drive
    `VDSS_ASSERT_IMPLY(a_launch_in_drive, clk, rst_n, state_reg.launch_on, state_reg.main_state == MS_DRIVE)
    // sequence state moves only when a pass completes
    `VDSS_ASSERT_NEXT(a_state_hold, clk, rst_n, !adv, $stable(state_reg))
    // an empty output register never stalls the status side
    `VDSS_ASSERT_IMPLY(a_no_false_stall, clk, rst_n, !out_valid_reg, status.ready)
    // discharge pulse goes with arrival in HV off
    `VDSS_ASSERT_IMPLY(a_discharge_hv_off, clk, rst_n, out_valid_reg && out_reg.discharge_request, out_reg.drive_state == DS_HV_OFF)

endmodule

[tb/sv/vehicle_drive_state_sequencer_checker.sv]
// Checker for the drive state sequencer: watches the config, status and result channels,
// predicts every result beat from its status beat and compares it field by field.
// Depends on vdss_pkg and the three channel interfaces.
module vehicle_drive_state_sequencer_checker
    import vdss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vdss_cfg_if  cfg,
    vdss_in_if   status,
    vdss_out_if  result,
    output int   mismatches,
    output int   pending_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] sound_ms_q;
    logic [9:0]  arm_q;
    logic [9:0]  abort_q;

    logic [2:0]  drive_q;
    logic [15:0] buzz_ms;
    logic        launch_q;
    logic [1:0]  phase_q;
    logic        speed_q;

    logic        rst_pulse;
    logic        dis_pulse;
    logic        start_pulse;
    logic        chg_pulse;

    out_item_t   awaited_outcomes[$];
    out_item_t   want;
    out_item_t   got;
    int          fails;

    function automatic void change_state(input logic [2:0] nxt);
        if (nxt != drive_q)
        begin
            if (drive_q == DS_HV_ON || drive_q == DS_DRIVE)
                rst_pulse = 1'b1;
            if (drive_q == DS_DRIVE)
                launch_q = 1'b0;
            drive_q   = nxt;
            chg_pulse = 1'b1;
            if (nxt == DS_HV_OFF)
                dis_pulse = 1'b1;
            if (nxt == DS_ENABLING)
                start_pulse = 1'b1;
            if (nxt == DS_BUZZER)
                buzz_ms = '0;
        end
    endfunction

    function automatic out_item_t sequence_pass(input in_item_t p);
        out_item_t r;
        logic attempted, success, hb_timeout;
        logic hv, en_timeout, inv_ready, inv_disabled;
        logic b_start, b_speed, b_lc_toggle, b_lc_press, b_lc_release;
        logic req, kick;

        attempted    = p.precharge_status[0];
        success      = p.precharge_status[1];
        hb_timeout   = p.precharge_status[2];
        hv           = p.inverter_status[0];
        en_timeout   = p.inverter_status[1];
        inv_ready    = p.inverter_status[2];
        inv_disabled = p.inverter_status[3];
        b_start      = p.dash_buttons[0];
        b_speed      = p.dash_buttons[1];
        b_lc_toggle  = p.dash_buttons[2];
        b_lc_press   = p.dash_buttons[3];
        b_lc_release = p.dash_buttons[4];

        req         = 1'b0;
        kick        = 1'b0;
        rst_pulse   = 1'b0;
        dis_pulse   = 1'b0;
        start_pulse = 1'b0;
        chg_pulse   = 1'b0;

        case (drive_q)
            DS_STARTUP:
                change_state(DS_HV_OFF);
            DS_HV_OFF:
            begin
                req = !attempted || (hb_timeout && !success);
                if (success && !hb_timeout && hv)
                    change_state(DS_HV_ON);
            end
            DS_HV_ON:
            begin
                // fault return wins over the start request
                if (!hv || hb_timeout)
                    change_state(DS_HV_OFF);
                else if (b_start && p.brake_active)
                    change_state(DS_ENABLING);
            end
            DS_ENABLING:
            begin
                kick = 1'b1;
                if (!hv || hb_timeout)
                    change_state(DS_HV_OFF);
                else if (en_timeout)
                    change_state(DS_HV_ON);
                else if (inv_ready)
                    change_state(DS_BUZZER);
            end
            DS_BUZZER:
            begin
                kick = 1'b1;
                if (!hv)
                    change_state(DS_HV_OFF);
                else if (inv_disabled)
                    change_state(DS_HV_ON);
                else
                begin
                    if (p.time_tick && buzz_ms != '1)
                        buzz_ms = buzz_ms + 1'b1;
                    if (buzz_ms >= sound_ms_q)
                        change_state(DS_DRIVE);
                end
            end
            DS_DRIVE:
            begin
                kick = 1'b1;
                if (!hv)
                    change_state(DS_HV_OFF);
                else if (inv_disabled)
                    change_state(DS_HV_ON);
                else if (hb_timeout)
                    change_state(DS_HV_OFF);
                else
                begin
                    if (b_speed)
                        speed_q = !speed_q;
                    if (b_lc_toggle)
                    begin
                        launch_q = !launch_q;
                        phase_q  = LP_IDLE;
                    end
                    if (launch_q)
                    begin
                        case (phase_q)
                            LP_IDLE:
                            begin
                                if (b_lc_press && p.pedal_travel > arm_q &&
                                    !p.brake_active && !p.pedal_fault)
                                    phase_q = LP_WAITING;
                            end
                            LP_WAITING:
                            begin
                                if (p.pedal_travel < abort_q)
                                    phase_q = LP_IDLE;
                                else if (p.pedal_travel > arm_q && !b_lc_press && b_lc_release)
                                    phase_q = LP_LAUNCHING;
                            end
                            LP_LAUNCHING:
                            begin
                                if (p.brake_active || p.pedal_fault)
                                    phase_q = LP_FINISHED;
                            end
                            default:
                                launch_q = 1'b0;
                        endcase
                    end
                end
            end
            default:
            begin
                drive_q = DS_STARTUP;
                change_state(DS_HV_OFF);
            end
        endcase

        r.drive_state       = drive_q;
        r.inverter_enable   = kick;
        r.buzzer_on         = (drive_q == DS_BUZZER);
        r.lowside_on        = (drive_q == DS_DRIVE);
        r.launch_active     = launch_q;
        r.launch_phase      = phase_q;
        r.speed_mode        = speed_q;
        r.precharge_request = req;
        r.precharge_reset   = rst_pulse;
        r.discharge_request = dis_pulse;
        r.inverter_start    = start_pulse;
        r.state_changed     = chg_pulse;
        return r;
    endfunction

    function automatic void check_field(input string label, input int unsigned expv,
                                        input int unsigned actv);
        if (expv != actv)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, label, expv, actv);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_ms_q = READY_SOUND_MS_RST;
            arm_q      = LAUNCH_ARM_RST;
            abort_q    = LAUNCH_ABORT_RST;
            drive_q    = DS_STARTUP;
            buzz_ms    = '0;
            launch_q   = 1'b0;
            phase_q    = LP_IDLE;
            speed_q    = 1'b0;
            fails      = 0;
            awaited_outcomes.delete();
            mismatches    <= 0;
            pending_beats <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_READY_SOUND_MS: sound_ms_q = cfg.data;
                    CFG_LAUNCH_ARM:     arm_q      = cfg.data[9:0];
                    CFG_LAUNCH_ABORT:   abort_q    = cfg.data[9:0];
                    default:            ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                got = {result.drive_state, result.inverter_enable, result.buzzer_on,
                       result.lowside_on, result.launch_active, result.launch_phase,
                       result.speed_mode, result.precharge_request, result.precharge_reset,
                       result.discharge_request, result.inverter_start, result.state_changed};
                if (awaited_outcomes.size() == 0)
                begin
                    $display("%0t: result beat with nothing awaited, expected none, actual %h",
                             $time, got);
                    fails++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    check_field("drive_state", 32'(want.drive_state), 32'(got.drive_state));
                    check_field("inverter_enable", 32'(want.inverter_enable),
                                32'(got.inverter_enable));
                    check_field("buzzer_on", 32'(want.buzzer_on), 32'(got.buzzer_on));
                    check_field("lowside_on", 32'(want.lowside_on), 32'(got.lowside_on));
                    check_field("launch_active", 32'(want.launch_active),
                                32'(got.launch_active));
                    check_field("launch_phase", 32'(want.launch_phase),
                                32'(got.launch_phase));
                    check_field("speed_mode", 32'(want.speed_mode), 32'(got.speed_mode));
                    check_field("precharge_request", 32'(want.precharge_request),
                                32'(got.precharge_request));
                    check_field("precharge_reset", 32'(want.precharge_reset),
                                32'(got.precharge_reset));
                    check_field("discharge_request", 32'(want.discharge_request),
                                32'(got.discharge_request));
                    check_field("inverter_start", 32'(want.inverter_start),
                                32'(got.inverter_start));
                    check_field("state_changed", 32'(want.state_changed),
                                32'(got.state_changed));
                end
            end

            if (status.valid && status.ready)
                awaited_outcomes.push_back(sequence_pass({status.time_tick,
                    status.precharge_status, status.inverter_status, status.dash_buttons,
                    status.brake_active, status.pedal_travel, status.pedal_fault}));

            mismatches    <= fails;
            pending_beats <= awaited_outcomes.size();
        end
    end

endmodule

[tb/sv/vehicle_drive_state_sequencer_tb.sv]
// Top of the drive state sequencer testbench: clock, reset, config writes and status beats.
// Depends on vdss_pkg, the channel interfaces, the block and the checker module.
// The checker predicts and compares; this module only drives stimulus and gives the verdict.
module vehicle_drive_state_sequencer_tb
    import vdss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RUN_LIMIT_NS  = 5_000_000;
    localparam int          PHASES        = 8;
    localparam int          PHASE_PASSES  = 110;
    localparam int          IN_W          = $bits(in_item_t);
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;

    localparam logic [2:0]  PC_ATTEMPTED  = 3'b001;
    localparam logic [2:0]  PC_SUCCESS    = 3'b010;
    localparam logic [2:0]  PC_TIMEOUT    = 3'b100;
    localparam logic [2:0]  PC_GOOD       = PC_ATTEMPTED | PC_SUCCESS;
    localparam logic [3:0]  INV_HV        = 4'b0001;
    localparam logic [3:0]  INV_EN_TO     = 4'b0010;
    localparam logic [3:0]  INV_READY     = 4'b0100;
    localparam logic [3:0]  INV_DISABLED  = 4'b1000;
    localparam logic [4:0]  BTN_START     = 5'b00001;
    localparam logic [4:0]  BTN_SPEED     = 5'b00010;
    localparam logic [4:0]  BTN_LC_TOGGLE = 5'b00100;
    localparam logic [4:0]  BTN_LC_PRESS  = 5'b01000;
    localparam logic [4:0]  BTN_LC_LONG   = 5'b10000;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_STARVED} rx_style_t;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   pending_beats;

    rx_style_t rx_style = RX_OPEN;
    int        rx_span  = 0;

    logic [15:0] sound_set [PHASES] = '{16'd0, 16'd1, 16'd3, 16'd2, 16'hFFFF, 16'd0, 16'd0,
                                        16'd0};
    logic [9:0]  arm_set   [PHASES] = '{10'd0, 10'd1023, 10'd800, 10'd1000, 10'd900, 10'd0,
                                        10'd0, 10'd0};
    logic [9:0]  abort_set [PHASES] = '{10'd0, 10'd1023, 10'd500, 10'd0, 10'd700, 10'd0,
                                        10'd0, 10'd0};

    vdss_cfg_if cfg_bus ();
    vdss_in_if  status_bus ();
    vdss_out_if result_bus ();

    vehicle_drive_state_sequencer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .status (status_bus),
        .result (result_bus)
    );

    vehicle_drive_state_sequencer_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_bus),
        .status        (status_bus),
        .result        (result_bus),
        .mismatches    (mismatches),
        .pending_beats (pending_beats)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side back-pressure: spans of open, choppy or starved acceptance
    always @(posedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_style <= rx_style_t'($urandom_range(0, 2));
            rx_span  <= $urandom_range(3, 40);
        end
        else
            rx_span <= rx_span - 1;
        case (rx_style)
            RX_OPEN:   result_bus.ready <= 1'b1;
            RX_CHOPPY: result_bus.ready <= 1'($urandom_range(0, 1));
            default:   result_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic in_item_t pass_of(input int tick, input logic [2:0] pc,
                                         input logic [3:0] inv, input logic [4:0] dash,
                                         input int brake, input logic [9:0] travel,
                                         input int fault);
        return {1'(tick), pc, inv, dash, 1'(brake), travel, 1'(fault)};
    endfunction

    // well-formed passes mostly keep HV up and precharge good so the sequence reaches drive
    function automatic in_item_t shaped_pass(input bit noisy);
        in_item_t p;
        if (noisy)
        begin
            p = in_item_t'(IN_W'($urandom));
            p.pedal_travel = 10'($urandom_range(0, 1023));
        end
        else
        begin
            p.time_tick        = ($urandom_range(0, 9) < 7);
            p.precharge_status = ($urandom_range(0, 19) == 0) ? 3'($urandom) : PC_GOOD;
            p.inverter_status  = (($urandom_range(0, 99) != 0) ? INV_HV : 4'b0)
                               | (($urandom_range(0, 29) == 0) ? INV_EN_TO : 4'b0)
                               | (($urandom_range(0, 9) < 6) ? INV_READY : 4'b0)
                               | (($urandom_range(0, 99) == 0) ? INV_DISABLED : 4'b0);
            p.dash_buttons     = (($urandom_range(0, 9) < 4) ? BTN_START : 5'b0)
                               | (($urandom_range(0, 9) == 0) ? BTN_SPEED : 5'b0)
                               | (($urandom_range(0, 19) == 0) ? BTN_LC_TOGGLE : 5'b0)
                               | (($urandom_range(0, 9) < 4) ? BTN_LC_PRESS : 5'b0)
                               | (($urandom_range(0, 9) < 4) ? BTN_LC_LONG : 5'b0);
            p.brake_active     = ($urandom_range(0, 9) < 3);
            p.pedal_travel     = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
                                                      : 10'($urandom_range(600, 1023));
            p.pedal_fault      = ($urandom_range(0, 19) == 0);
        end
        return p;
    endfunction

    task automatic put_fields(input in_item_t p);
        status_bus.time_tick        <= p.time_tick;
        status_bus.precharge_status <= p.precharge_status;
        status_bus.inverter_status  <= p.inverter_status;
        status_bus.dash_buttons     <= p.dash_buttons;
        status_bus.brake_active     <= p.brake_active;
        status_bus.pedal_travel     <= p.pedal_travel;
        status_bus.pedal_fault      <= p.pedal_fault;
    endtask

    task automatic send_pass(input in_item_t p);
        status_bus.valid <= 1'b1;
        put_fields(p);
        @(posedge clk);
        while (!status_bus.ready)
            @(posedge clk);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            status_bus.valid <= 1'b0;
            put_fields(in_item_t'(IN_W'($urandom)));
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain();
        status_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] sound, input logic [9:0] arm,
                                 input logic [9:0] abort_lvl);
        write_reg(CFG_READY_SOUND_MS, sound);
        write_reg(CFG_LAUNCH_ARM, {6'($urandom), arm});
        write_reg(CFG_LAUNCH_ABORT, {6'($urandom), abort_lvl});
        write_reg(CFG_UNUSED, 16'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    initial
    begin
        int  sent;
        int  burst;
        int  ph;
        bit  noisy;

        rst_n                       = 1'b0;
        cfg_bus.valid               = 1'b0;
        cfg_bus.index               = CFG_READY_SOUND_MS;
        cfg_bus.data                = '0;
        status_bus.valid            = 1'b0;
        status_bus.time_tick        = 1'b0;
        status_bus.precharge_status = '0;
        status_bus.inverter_status  = '0;
        status_bus.dash_buttons     = '0;
        status_bus.brake_active     = 1'b0;
        status_bus.pedal_travel     = '0;
        status_bus.pedal_fault      = 1'b0;
        result_bus.ready            = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // bring-up paths and priorities under reset settings
        send_pass(pass_of(0, 3'b000, 4'b0000, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(1, 3'b000, INV_HV, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(1, PC_ATTEMPTED | PC_TIMEOUT, INV_HV, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD | PC_TIMEOUT, INV_HV, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(0, PC_SUCCESS | PC_TIMEOUT, INV_HV, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, 4'b0000, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, INV_HV, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, 4'b0000, BTN_START, 1, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, INV_HV, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD | PC_TIMEOUT, INV_HV, BTN_START, 1, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, INV_HV, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, INV_HV, BTN_START, 0, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, INV_HV, BTN_START, 1, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, INV_HV | INV_EN_TO | INV_READY, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, INV_HV, BTN_START, 1, 10'd0, 0));
        send_pass(pass_of(0, PC_GOOD, INV_HV | INV_READY, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(1, PC_GOOD, INV_HV | INV_DISABLED, 5'b00000, 0, 10'd0, 0));
        send_pass(pass_of(1, PC_GOOD, INV_HV, 5'b11111, 1, 10'd1023, 1));
        send_pass(pass_of(1, PC_GOOD, INV_HV | INV_READY, 5'b11111, 1, 10'd1023, 1));
        send_pass(pass_of(1, 3'b111, INV_HV, 5'b00000, 0, 10'd1000, 0));
        send_pass(pass_of(1, PC_GOOD, 4'b0000, 5'b00000, 0, 10'd1001, 0));

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            if (ph >= 5)
                load_settings(16'($urandom_range(0, 12)), 10'($urandom_range(0, 1023)),
                              10'($urandom_range(0, 1023)));
            else
                load_settings(sound_set[ph], arm_set[ph], abort_set[ph]);

            sent = 0;
            while (sent < PHASE_PASSES)
            begin
                burst = $urandom_range(1, 24);
                noisy = ($urandom_range(0, 6) == 0);
                repeat (burst)
                    send_pass(shaped_pass(noisy));
                sent += burst;
                pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
